### hw/rtl/slm_pkg.sv
// Shared types and constants for the stereo level meter peak tagger.
package slm_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VU_COEF       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_RELEASE  = 3'd4;

  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned THR_W      = 24;
  localparam int unsigned COEF_REG_W = 16;
  localparam int unsigned LEVEL_W    = 24;
  localparam int unsigned POS_W      = 48;
  localparam int unsigned OUT_DATA_W = 176;

  localparam logic [THR_W-1:0]      PEAK_THRESHOLD_RST  = 24'd7476617;
  localparam logic [THR_W-1:0]      REARM_THRESHOLD_RST = 24'd6663384;
  localparam logic [COEF_REG_W-1:0] VU_COEF_RST         = 16'd2488;
  localparam logic [COEF_REG_W-1:0] PEAK_RELEASE_RST    = 16'd64031;

  localparam int unsigned DEF_SAMPLE_BITS = 24;
  localparam int unsigned DEF_MAX_BLOCK   = 4096;
  localparam int unsigned DEF_COEF_BITS   = 16;

  // Operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL,
    OP_SQRT
  } au_op_e;

  typedef struct packed {
    logic   start;
    au_op_e op;
  } au_req_t;

endpackage

### hw/rtl/stereo_level_meter_peak_tagger.sv
// Top level of the stereo level meter with peak hold, release and peak-event marks.
//
// Input stream: one stereo sample per request; s_axis_tlast marks the last sample
// of a host block. Transport flags and the position are taken from the last sample.
// Plain samples are accepted back to back. The block-end sample starts a sequence on
// one shared iterative unit: divide left/right (SUM_W steps each), smoothing
// multiply left/right (16 steps each), square root left/right (SAMPLE_BITS steps
// each), envelope multiply left/right (16 steps each). Until the result is loaded
// into the output register, s_axis_tready is low.
// One result request leaves per block on the master side. It waits in an output
// register; if the receiver stalls, samples keep being accepted and only the end of
// the next block waits for the register to drain.
// Reset clears the accumulators, smoothing and envelope state, the event tracker and
// the registers to defaults. Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take
// effect at once; the user makes them only while the block is idle (not enforced).
module stereo_level_meter_peak_tagger import slm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned MAX_BLOCK   = DEF_MAX_BLOCK,
  parameter int unsigned COEF_BITS   = DEF_COEF_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample_left, sample_right, playing, record_request, monitor_on, position
  input  logic [((2*SAMPLE_BITS+51+7)/8)*8-1:0] s_axis_tdata,
  input  logic                  s_axis_tlast,   // block_end
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // level_left, level_right, peak_env_left, peak_env_right, recording,
  // capture_started, capture_finished, mark_valid, mark_peak, mark_position,
  // mark_monitor
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SQ_W  = 2 * SB - 1;
  localparam int unsigned SUM_W = SQ_W + $clog2(MAX_BLOCK);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned B_W   = (CNT_W > COEF_REG_W) ? CNT_W : COEF_REG_W;
  localparam int unsigned RES_W = SUM_W + COEF_REG_W;
  localparam int unsigned CMP_W = (SB > THR_W) ? SB : THR_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV_L = 4'd1;
  localparam logic [3:0] ST_DIV_R = 4'd2;
  localparam logic [3:0] ST_SM_L  = 4'd3;
  localparam logic [3:0] ST_SM_R  = 4'd4;
  localparam logic [3:0] ST_SQ_L  = 4'd5;
  localparam logic [3:0] ST_SQ_R  = 4'd6;
  localparam logic [3:0] ST_ENV_L = 4'd7;
  localparam logic [3:0] ST_ENV_R = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  // input unpack
  logic [SB-1:0]    in_l, in_r;
  logic [POS_W-1:0] in_pos;
  assign in_l   = s_axis_tdata[SB-1:0];
  assign in_r   = s_axis_tdata[2*SB-1:SB];
  assign in_pos = s_axis_tdata[2*SB+3 +: POS_W];

  // config registers
  logic                  mode_q;
  logic [THR_W-1:0]      pk_thr_q, rearm_q;
  logic [COEF_REG_W-1:0] vu_coef_q, release_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      pk_thr_q  <= PEAK_THRESHOLD_RST;
      rearm_q   <= REARM_THRESHOLD_RST;
      vu_coef_q <= VU_COEF_RST;
      release_q <= PEAK_RELEASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_METER_MODE:      mode_q    <= cfg_wdata_i[0];
        CFG_PEAK_THRESHOLD:  pk_thr_q  <= cfg_wdata_i[THR_W-1:0];
        CFG_REARM_THRESHOLD: rearm_q   <= cfg_wdata_i[THR_W-1:0];
        CFG_VU_COEF:         vu_coef_q <= cfg_wdata_i[COEF_REG_W-1:0];
        CFG_PEAK_RELEASE:    release_q <= cfg_wdata_i[COEF_REG_W-1:0];
        default:             mode_q    <= mode_q;
      endcase
    end
  end

  logic [3:0] state_q, state_d;
  logic       issued_q, issued_d;
  logic       in_acc, acc_clear;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // block accumulators
  logic [SUM_W-1:0] sum_l, sum_r;
  logic [SB-1:0]    bp_l, bp_r;
  logic [CNT_W-1:0] count;

  slm_accum #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_acc),
    .clear_i       (acc_clear),
    .sample_left_i (in_l),
    .sample_right_i(in_r),
    .sum_left_o    (sum_l),
    .sum_right_o   (sum_r),
    .peak_left_o   (bp_l),
    .peak_right_o  (bp_r),
    .count_o       (count)
  );

  // shared arithmetic unit
  au_req_t          au_req;
  logic [SUM_W-1:0] au_a;
  logic [B_W-1:0]   au_b;
  logic             au_done;
  logic [RES_W-1:0] au_res;

  slm_arith #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (au_req),
    .a_i   (au_a),
    .b_i   (au_b),
    .done_o(au_done),
    .res_o (au_res)
  );

  // block-end working and persistent state
  logic [SQ_W-1:0]  ms_l_q, ms_l_d, ms_r_q, ms_r_d;
  logic [SQ_W-1:0]  sm_l_q, sm_l_d, sm_r_q, sm_r_d;
  logic [SB-1:0]    vu_l_q, vu_l_d, vu_r_q, vu_r_d;
  logic [SB-1:0]    env_l_q, env_l_d, env_r_q, env_r_d;
  logic             play_q, req_q, mon_q;
  logic [POS_W-1:0] pos_q;
  logic             was_rec_q, in_ev_q, held_mon_q;
  logic [SB-1:0]    emax_q;
  logic [POS_W-1:0] held_pos_q;

  logic             ge_l, ge_r;
  logic [SQ_W-1:0]  diff_l, diff_r, step;
  logic [SB-1:0]    decayed;

  assign ge_l   = ms_l_q >= sm_l_q;
  assign ge_r   = ms_r_q >= sm_r_q;
  assign diff_l = ge_l ? ms_l_q - sm_l_q : sm_l_q - ms_l_q;
  assign diff_r = ge_r ? ms_r_q - sm_r_q : sm_r_q - ms_r_q;
  assign step    = SQ_W'(au_res >> COEF_BITS);
  assign decayed = SB'(au_res >> COEF_BITS);

  // operand selection
  always_comb begin
    au_req.start = (state_q != ST_IDLE) && (state_q != ST_DONE) && !issued_q;
    au_req.op    = OP_DIV;
    au_a         = '0;
    au_b         = '0;
    case (state_q)
      ST_DIV_L: begin
        au_a = sum_l;
        au_b = B_W'(count);
      end
      ST_DIV_R: begin
        au_a = sum_r;
        au_b = B_W'(count);
      end
      ST_SM_L: begin
        au_req.op = OP_MUL;
        au_a      = SUM_W'(diff_l);
        au_b      = B_W'(vu_coef_q);
      end
      ST_SM_R: begin
        au_req.op = OP_MUL;
        au_a      = SUM_W'(diff_r);
        au_b      = B_W'(vu_coef_q);
      end
      ST_SQ_L: begin
        au_req.op = OP_SQRT;
        au_a      = SUM_W'(sm_l_q);
      end
      ST_SQ_R: begin
        au_req.op = OP_SQRT;
        au_a      = SUM_W'(sm_r_q);
      end
      ST_ENV_L: begin
        au_req.op = OP_MUL;
        au_a      = SUM_W'(env_l_q);
        au_b      = B_W'(release_q);
      end
      ST_ENV_R: begin
        au_req.op = OP_MUL;
        au_a      = SUM_W'(env_r_q);
        au_b      = B_W'(release_q);
      end
      default: au_a = '0;
    endcase
  end

  // peak event tracker, evaluated in the final state
  logic             rec, started, detect, emit;
  logic [SB-1:0]    p;
  logic [CMP_W-1:0] p_c;
  logic             ev_d, held_mon_d;
  logic [SB-1:0]    emax_d;
  logic [POS_W-1:0] held_pos_d;

  always_comb begin
    rec        = req_q && play_q;
    started    = rec && !was_rec_q;
    detect     = rec || (mon_q && play_q);
    p          = (bp_l > bp_r) ? bp_l : bp_r;
    p_c        = CMP_W'(p);
    ev_d       = started ? 1'b0 : in_ev_q;
    emax_d     = started ? '0 : emax_q;
    held_pos_d = held_pos_q;
    held_mon_d = held_mon_q;
    emit       = 1'b0;
    if (detect) begin
      if (p_c >= CMP_W'(pk_thr_q)) begin
        if (!ev_d || (p > emax_d)) begin
          ev_d       = 1'b1;
          emax_d     = p;
          held_pos_d = pos_q;
          held_mon_d = !rec;
        end
      end else if (ev_d && (p_c < CMP_W'(rearm_q))) begin
        emit = 1'b1;
      end
    end else if (ev_d) begin
      emit = 1'b1;
    end
    if (emit) ev_d = 1'b0;
  end

  logic                  out_load;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data;
  logic [LEVEL_W-1:0]    lvl_l, lvl_r;

  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign acc_clear = out_load;
  assign lvl_l     = mode_q ? LEVEL_W'(env_l_q) : LEVEL_W'(vu_l_q);
  assign lvl_r     = mode_q ? LEVEL_W'(env_r_q) : LEVEL_W'(vu_r_q);
  assign out_data  = {3'b000,
                      emit & held_mon_d,
                      emit ? held_pos_d : {POS_W{1'b0}},
                      emit ? LEVEL_W'(emax_d) : {LEVEL_W{1'b0}},
                      emit,
                      !rec && was_rec_q,
                      started,
                      rec,
                      LEVEL_W'(env_r_q),
                      LEVEL_W'(env_l_q),
                      lvl_r,
                      lvl_l};

  // sequencer and capture of unit results
  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    ms_l_d   = ms_l_q;
    ms_r_d   = ms_r_q;
    sm_l_d   = sm_l_q;
    sm_r_d   = sm_r_q;
    vu_l_d   = vu_l_q;
    vu_r_d   = vu_r_q;
    env_l_d  = env_l_q;
    env_r_d  = env_r_q;
    if (au_req.start) issued_d = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tlast) state_d = ST_DIV_L;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        if (au_done) begin
          issued_d = 1'b0;
          state_d  = state_q + 4'd1;
          case (state_q)
            ST_DIV_L: ms_l_d  = SQ_W'(au_res);
            ST_DIV_R: ms_r_d  = SQ_W'(au_res);
            ST_SM_L:  sm_l_d  = ge_l ? sm_l_q + step : sm_l_q - step;
            ST_SM_R:  sm_r_d  = ge_r ? sm_r_q + step : sm_r_q - step;
            ST_SQ_L:  vu_l_d  = SB'(au_res);
            ST_SQ_R:  vu_r_d  = SB'(au_res);
            ST_ENV_L: env_l_d = (bp_l > decayed) ? bp_l : decayed;
            ST_ENV_R: env_r_d = (bp_r > decayed) ? bp_r : decayed;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      sm_l_q      <= '0;
      sm_r_q      <= '0;
      env_l_q     <= '0;
      env_r_q     <= '0;
      was_rec_q   <= 1'b0;
      in_ev_q     <= 1'b0;
      emax_q      <= '0;
      held_pos_q  <= '0;
      held_mon_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      sm_l_q   <= sm_l_d;
      sm_r_q   <= sm_r_d;
      env_l_q  <= env_l_d;
      env_r_q  <= env_r_d;
      if (out_load) begin
        was_rec_q   <= rec;
        in_ev_q     <= ev_d;
        emax_q      <= emax_d;
        held_pos_q  <= held_pos_d;
        held_mon_q  <= held_mon_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ms_l_q <= ms_l_d;
    ms_r_q <= ms_r_d;
    vu_l_q <= vu_l_d;
    vu_r_q <= vu_r_d;
    if (in_acc && s_axis_tlast) begin
      play_q <= s_axis_tdata[2*SB];
      req_q  <= s_axis_tdata[2*SB+1];
      mon_q  <= s_axis_tdata[2*SB+2];
      pos_q  <= in_pos;
    end
    if (out_load) out_data_q <= out_data;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### hw/rtl/slm_accum.sv
// Per-block accumulation of squared magnitudes, peaks and sample count.
module slm_accum import slm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned MAX_BLOCK   = DEF_MAX_BLOCK
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  input  logic                                         clear_i,
  input  logic [SAMPLE_BITS-1:0]                       sample_left_i,
  input  logic [SAMPLE_BITS-1:0]                       sample_right_i,
  output logic [2*SAMPLE_BITS-1+$clog2(MAX_BLOCK)-1:0] sum_left_o,
  output logic [2*SAMPLE_BITS-1+$clog2(MAX_BLOCK)-1:0] sum_right_o,
  output logic [SAMPLE_BITS-1:0]                       peak_left_o,
  output logic [SAMPLE_BITS-1:0]                       peak_right_o,
  output logic [$clog2(MAX_BLOCK+1)-1:0]               count_o
);

  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int unsigned SUM_W = SQ_W + $clog2(MAX_BLOCK);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);

  logic [SUM_W-1:0]       sum_l_q, sum_l_d, sum_r_q, sum_r_d;
  logic [SAMPLE_BITS-1:0] pk_l_q, pk_l_d, pk_r_q, pk_r_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] mag_l, mag_r;
  logic [SQ_W-1:0]        sq_l, sq_r;

  // two's complement magnitude; the most negative code maps to 2^(N-1)
  assign mag_l = sample_left_i[SAMPLE_BITS-1]  ? (~sample_left_i + 1'b1)  : sample_left_i;
  assign mag_r = sample_right_i[SAMPLE_BITS-1] ? (~sample_right_i + 1'b1) : sample_right_i;
  assign sq_l  = SQ_W'(mag_l) * SQ_W'(mag_l);
  assign sq_r  = SQ_W'(mag_r) * SQ_W'(mag_r);

  always_comb begin
    sum_l_d = sum_l_q;
    sum_r_d = sum_r_q;
    pk_l_d  = pk_l_q;
    pk_r_d  = pk_r_q;
    cnt_d   = cnt_q;
    if (clear_i) begin
      sum_l_d = '0;
      sum_r_d = '0;
      pk_l_d  = '0;
      pk_r_d  = '0;
      cnt_d   = '0;
    end else if (valid_i && (cnt_q < CNT_W'(MAX_BLOCK))) begin
      sum_l_d = sum_l_q + SUM_W'(sq_l);
      sum_r_d = sum_r_q + SUM_W'(sq_r);
      if (mag_l > pk_l_q) pk_l_d = mag_l;
      if (mag_r > pk_r_q) pk_r_d = mag_r;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_l_q <= '0;
      sum_r_q <= '0;
      pk_l_q  <= '0;
      pk_r_q  <= '0;
      cnt_q   <= '0;
    end else begin
      sum_l_q <= sum_l_d;
      sum_r_q <= sum_r_d;
      pk_l_q  <= pk_l_d;
      pk_r_q  <= pk_r_d;
      cnt_q   <= cnt_d;
    end
  end

  assign sum_left_o   = sum_l_q;
  assign sum_right_o  = sum_r_q;
  assign peak_left_o  = pk_l_q;
  assign peak_right_o = pk_r_q;
  assign count_o      = cnt_q;

endmodule

### hw/rtl/slm_arith.sv
// Shared iterative unit: restoring divide, shift-add multiply, digit square root.
module slm_arith import slm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned MAX_BLOCK   = DEF_MAX_BLOCK
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  au_req_t                                                 req_i,
  input  logic [2*SAMPLE_BITS-1+$clog2(MAX_BLOCK)-1:0]            a_i,
  input  logic [(($clog2(MAX_BLOCK+1) > COEF_REG_W) ?
                 $clog2(MAX_BLOCK+1) : COEF_REG_W)-1:0]           b_i,
  output logic                                                    done_o,
  output logic [2*SAMPLE_BITS-1+$clog2(MAX_BLOCK)+COEF_REG_W-1:0] res_o
);

  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int unsigned SUM_W  = SQ_W + $clog2(MAX_BLOCK);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned B_W    = (CNT_W > COEF_REG_W) ? CNT_W : COEF_REG_W;
  localparam int unsigned RES_W  = SUM_W + COEF_REG_W;
  localparam int unsigned K      = (SQ_W + 1) / 2;
  localparam int unsigned REM_W  = (CNT_W + 1 > K + 3) ? CNT_W + 1 : K + 3;
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic             busy_q, busy_d, done_q, done_d;
  au_op_e           op_q, op_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RES_W-1:0] a_q, a_d, acc_q, acc_d;
  logic [B_W-1:0]   b_q, b_d;
  logic [REM_W-1:0] rem_q, rem_d, rem_sh, trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    step_d = step_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    rem_sh = '0;
    trial  = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      a_d    = RES_W'(a_i);
      b_d    = b_i;
      acc_d  = '0;
      rem_d  = '0;
      case (req_i.op)
        OP_DIV:  step_d = STEP_W'(SUM_W);
        OP_MUL:  step_d = STEP_W'(COEF_REG_W);
        OP_SQRT: step_d = STEP_W'(K);
        default: step_d = STEP_W'(1);
      endcase
    end else if (busy_q) begin
      case (op_q)
        OP_DIV: begin
          rem_sh = {rem_q[REM_W-2:0], a_q[SUM_W-1]};
          a_d    = a_q << 1;
          if (rem_sh >= REM_W'(b_q)) begin
            rem_d = rem_sh - REM_W'(b_q);
            acc_d = {acc_q[RES_W-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            acc_d = {acc_q[RES_W-2:0], 1'b0};
          end
        end
        OP_MUL: begin
          acc_d = acc_q + (b_q[0] ? a_q : '0);
          a_d   = a_q << 1;
          b_d   = b_q >> 1;
        end
        OP_SQRT: begin
          rem_sh = {rem_q[REM_W-3:0], a_q[2*K-1 -: 2]};
          trial  = REM_W'({acc_q[K-1:0], 2'b01});
          a_d    = a_q << 2;
          if (rem_sh >= trial) begin
            rem_d = rem_sh - trial;
            acc_d = {acc_q[RES_W-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            acc_d = {acc_q[RES_W-2:0], 1'b0};
          end
        end
        default: acc_d = acc_q;
      endcase
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule
